// ===== src/dpcr_pkg.sv =====
// Shared types, widths and helpers for the disc pair collision response block.
// No dependencies; used by disc_pair_collision_response.
package dpcr_pkg;

  localparam int FRAC_BITS_DEF = 8;

  // field widths of the ports
  localparam int FIELD_W = 20;
  localparam int RAD_W   = 16;
  localparam int MASS_W  = 16;
  localparam int TOL_W   = 8;
  localparam logic [TOL_W-1:0] TOL_RESET = 8'd26;

  // internal widths, bounded by the field ranges
  localparam int DIFF_W     = FIELD_W + 1;  // difference of two fields
  localparam int REACH_W    = 18;           // ra + rb + tol
  localparam int REACH2_W   = 2 * REACH_W;
  localparam int D2_W       = 2 * DIFF_W;   // dx^2 + dy^2
  localparam int SQRT_IN_W  = 36;           // d2 below reach^2 when in contact
  localparam int DIST_W     = SQRT_IN_W / 2;
  localparam int DXN_W      = DIST_W + 1;   // |d| <= dist when in contact
  localparam int GAP_W      = DIST_W + 1;
  localparam int VN_W       = 24;
  localparam int MSUM_W     = MASS_W + 1;
  localparam int MPROD_W    = MASS_W + 1 + VN_W;
  localparam int MNUM_W     = MPROD_W + 1;
  localparam int MQ_W       = 24;
  localparam int DV_W       = MQ_W + 1;
  localparam int ACC_W      = 48;

  localparam logic signed [ACC_W-1:0] FIELD_MAX = ACC_W'(2 ** (FIELD_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] FIELD_MIN = ACC_W'(-(2 ** (FIELD_W - 1)));

  // one candidate pair as it travels down the pipe
  typedef struct packed {
    logic signed [FIELD_W-1:0] pax;
    logic signed [FIELD_W-1:0] pay;
    logic signed [FIELD_W-1:0] pbx;
    logic signed [FIELD_W-1:0] pby;
    logic signed [FIELD_W-1:0] vax;
    logic signed [FIELD_W-1:0] vay;
    logic signed [FIELD_W-1:0] vbx;
    logic signed [FIELD_W-1:0] vby;
    logic [RAD_W-1:0]          ra;
    logic [RAD_W-1:0]          rb;
    logic [MASS_W-1:0]         ma;
    logic [MASS_W-1:0]         mb;
  } pair_t;

  localparam int PAIR_W = $bits(pair_t);

  // clamp a wide signed value to the field range
  function automatic logic signed [FIELD_W-1:0] sat_field(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    c = v;
    if (v > FIELD_MAX) c = FIELD_MAX;
    if (v < FIELD_MIN) c = FIELD_MIN;
    return c[FIELD_W-1:0];
  endfunction

endpackage

// ===== src/dpcr_delay.sv =====
// Enabled shift line that carries side data alongside a pipelined unit.
// Depends on nothing.
module dpcr_delay #(
  parameter int W = 8,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [D];

  // shift on every enabled cycle
  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < D; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q = sr_r[D-1];

endmodule

// ===== src/dpcr_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on nothing.
module dpcr_isqrt #(
  parameter int IW = 36
) (
  input  logic            clk,
  input  logic            en,
  input  logic [IW-1:0]   v,
  output logic [IW/2-1:0] root
);

  localparam int OW = IW / 2;

  logic [IW-1:0] rem_r [OW];
  logic [IW-1:0] res_r [OW];

  for (genvar s = 0; s < OW; s++) begin : g_stage
    localparam logic [IW-1:0] BIT = IW'(1) << (IW - 2 - 2 * s);
    logic [IW-1:0] rem_in, res_in, trial, rem_nxt, res_nxt;

    if (s == 0) begin : g_first
      assign rem_in = v;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign res_in = res_r[s-1];
    end

    // try the next root bit
    always_comb begin
      trial = res_in + BIT;
      if (rem_in >= trial) begin
        rem_nxt = rem_in - trial;
        res_nxt = (res_in >> 1) + BIT;
      end else begin
        rem_nxt = rem_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        res_r[s] <= res_nxt;
      end
    end
  end

  assign root = res_r[OW-1][OW-1:0];

endmodule

// ===== src/dpcr_rdiv.sv =====
// Pipelined signed divide by a positive value, rounded to nearest, ties up.
// Depends on nothing; one quotient bit per stage.
module dpcr_rdiv #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 18,
  parameter int QW    = 18
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic signed [QW:0]      quo
);

  localparam int MW = NUM_W + 2;
  localparam int DW = DEN_W + 1;
  localparam int CW = (MW > DW + QW) ? MW : DW + QW;

  logic [MW-1:0] rem_r [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic [DW-1:0] d_r   [QW+1];
  logic          neg_r [QW+1];
  logic signed [QW:0] quo_r;

  logic signed [MW-1:0] n_s;
  logic [DW-1:0]        d_s;
  logic [MW-1:0]        m0;

  // floor((2n + d) / 2d) as a magnitude divide
  always_comb begin
    n_s = (MW'(num) <<< 1) + $signed(MW'(den));
    d_s = {den, 1'b0};
    if (n_s[MW-1]) begin
      m0 = MW'(-n_s) + MW'(d_s) - MW'(1);
    end else begin
      m0 = MW'(n_s);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= m0;
      q_r[0]   <= '0;
      d_r[0]   <= d_s;
      neg_r[0] <= n_s[MW-1];
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    logic [CW-1:0] dsh, rem_c;
    logic          ge;
    logic [MW-1:0] rem_nxt;
    logic [QW-1:0] q_nxt;

    // restoring step for quotient bit B
    always_comb begin
      dsh     = CW'(d_r[s]) << B;
      rem_c   = CW'(rem_r[s]);
      ge      = rem_c >= dsh;
      rem_nxt = ge ? MW'(rem_c - dsh) : rem_r[s];
      q_nxt   = ge ? (q_r[s] | (QW'(1) << B)) : q_r[s];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= rem_nxt;
        q_r[s+1]   <= q_nxt;
        d_r[s+1]   <= d_r[s];
        neg_r[s+1] <= neg_r[s];
      end
    end
  end

  // restore the sign
  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_r[QW]) quo_r <= -$signed({1'b0, q_r[QW]});
      else           quo_r <= $signed({1'b0, q_r[QW]});
    end
  end

  assign quo = quo_r;

endmodule

// ===== src/disc_pair_collision_response.sv =====
// Elastic collision response for one pair of discs per word, fully pipelined.
// One word per cycle while the output is not stalled.
// Depth is set by the 18-stage square root, the normal divider (2*FRAC_BITS+4
// stages) and the mass-weight dividers (26 stages); a stall holds the whole pipe.
// Synchronous active-low reset clears the valid bits and sets the tolerance to 26.
// Uses dpcr_pkg, dpcr_delay, dpcr_isqrt and dpcr_rdiv.
module disc_pair_collision_response #(
  parameter int FRAC_BITS = dpcr_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,

  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [dpcr_pkg::FIELD_W-1:0]    in_pos_a_x,
  input  logic signed [dpcr_pkg::FIELD_W-1:0]    in_pos_a_y,
  input  logic signed [dpcr_pkg::FIELD_W-1:0]    in_pos_b_x,
  input  logic signed [dpcr_pkg::FIELD_W-1:0]    in_pos_b_y,
  input  logic signed [dpcr_pkg::FIELD_W-1:0]    in_vel_a_x,
  input  logic signed [dpcr_pkg::FIELD_W-1:0]    in_vel_a_y,
  input  logic signed [dpcr_pkg::FIELD_W-1:0]    in_vel_b_x,
  input  logic signed [dpcr_pkg::FIELD_W-1:0]    in_vel_b_y,
  input  logic [dpcr_pkg::RAD_W-1:0]             in_radius_a,
  input  logic [dpcr_pkg::RAD_W-1:0]             in_radius_b,
  input  logic [dpcr_pkg::MASS_W-1:0]            in_mass_a,
  input  logic [dpcr_pkg::MASS_W-1:0]            in_mass_b,

  input  logic                                   cfg_we,
  input  logic [dpcr_pkg::TOL_W-1:0]             cfg_wdata,

  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [dpcr_pkg::FIELD_W-1:0]    out_new_pos_a_x,
  output logic signed [dpcr_pkg::FIELD_W-1:0]    out_new_pos_a_y,
  output logic signed [dpcr_pkg::FIELD_W-1:0]    out_new_pos_b_x,
  output logic signed [dpcr_pkg::FIELD_W-1:0]    out_new_pos_b_y,
  output logic signed [dpcr_pkg::FIELD_W-1:0]    out_new_vel_a_x,
  output logic signed [dpcr_pkg::FIELD_W-1:0]    out_new_vel_a_y,
  output logic signed [dpcr_pkg::FIELD_W-1:0]    out_new_vel_b_x,
  output logic signed [dpcr_pkg::FIELD_W-1:0]    out_new_vel_b_y,
  output logic                                   out_collided
);

  localparam int NB       = 2 * FRAC_BITS;
  localparam int NQ_W     = NB + 2;
  localparam int NW       = NQ_W + 1;
  localparam int NUMN_W   = dpcr_pkg::DXN_W + NB;
  localparam int PR_W     = dpcr_pkg::DIFF_W + NW;
  localparam int SUM_W    = PR_W + 1;
  localparam int MV_W     = NW + dpcr_pkg::DV_W;
  localparam int MC_W     = NW + dpcr_pkg::GAP_W;
  localparam int PAIR_W   = dpcr_pkg::PAIR_W;
  localparam int SQRT_LAT = dpcr_pkg::SQRT_IN_W / 2;
  localparam int NDIV_LAT = NQ_W + 2;
  localparam int MDIV_LAT = dpcr_pkg::MQ_W + 2;
  localparam int LAT      = 4 + SQRT_LAT + NDIV_LAT + 3 + MDIV_LAT + 2;
  localparam int SIDE_N_W = PAIR_W + 1 + dpcr_pkg::DIST_W;
  localparam int SIDE_M_W = PAIR_W + 1 + 2 * NW + dpcr_pkg::GAP_W;

  localparam logic signed [SUM_W-1:0] HALF_N = SUM_W'(1) <<< (NB - 1);
  localparam logic signed [MV_W:0]    HALF_V = (MV_W + 1)'(1) <<< (NB - 1);
  localparam logic signed [MC_W:0]    HALF_C = (MC_W + 1)'(1) <<< NB;

  logic           en;
  logic [LAT-1:0] vld_r;
  logic [dpcr_pkg::TOL_W-1:0] tol_r;

  // global advance: the pipe moves unless the output word is held
  assign en       = !(vld_r[LAT-1] && out_stall);
  assign in_stall = vld_r[LAT-1] && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= dpcr_pkg::TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // ---------------- contact test ----------------
  dpcr_pkg::pair_t in_pair, p1_r, p2_r, p3_r, p4_r;
  logic signed [dpcr_pkg::DIFF_W-1:0] dx_r, dy_r;
  logic [dpcr_pkg::REACH_W-1:0]       reach_r;
  logic [dpcr_pkg::D2_W-1:0]          sqx_r, sqy_r, d2_nxt, d2_r;
  logic [dpcr_pkg::REACH2_W-1:0]      reach2_r;
  logic                               contact_r;

  always_comb begin
    in_pair.pax = in_pos_a_x;
    in_pair.pay = in_pos_a_y;
    in_pair.pbx = in_pos_b_x;
    in_pair.pby = in_pos_b_y;
    in_pair.vax = in_vel_a_x;
    in_pair.vay = in_vel_a_y;
    in_pair.vbx = in_vel_b_x;
    in_pair.vby = in_vel_b_y;
    in_pair.ra  = in_radius_a;
    in_pair.rb  = in_radius_b;
    in_pair.ma  = in_mass_a;
    in_pair.mb  = in_mass_b;
  end

  assign d2_nxt = sqx_r + sqy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r      <= in_pair;
      p2_r      <= p1_r;
      dx_r      <= dpcr_pkg::DIFF_W'(p1_r.pbx) - dpcr_pkg::DIFF_W'(p1_r.pax);
      dy_r      <= dpcr_pkg::DIFF_W'(p1_r.pby) - dpcr_pkg::DIFF_W'(p1_r.pay);
      reach_r   <= dpcr_pkg::REACH_W'(p1_r.ra) + dpcr_pkg::REACH_W'(p1_r.rb)
                 + dpcr_pkg::REACH_W'(tol_r);
      p3_r      <= p2_r;
      sqx_r     <= dpcr_pkg::D2_W'(dx_r * dx_r);
      sqy_r     <= dpcr_pkg::D2_W'(dy_r * dy_r);
      reach2_r  <= dpcr_pkg::REACH2_W'(reach_r) * dpcr_pkg::REACH2_W'(reach_r);
      p4_r      <= p3_r;
      d2_r      <= d2_nxt;
      contact_r <= (d2_nxt != '0) && (d2_nxt < dpcr_pkg::D2_W'(reach2_r));
    end
  end

  // ---------------- distance ----------------
  logic [dpcr_pkg::DIST_W-1:0] dist_s;
  logic [PAIR_W:0]             side_s_q;
  dpcr_pkg::pair_t             p_s;
  logic                        c_s;

  dpcr_isqrt #(.IW(dpcr_pkg::SQRT_IN_W)) u_isqrt (
    .clk (clk),
    .en  (en),
    .v   (d2_r[dpcr_pkg::SQRT_IN_W-1:0]),
    .root(dist_s)
  );

  dpcr_delay #(.W(PAIR_W + 1), .D(SQRT_LAT)) u_dly_sqrt (
    .clk(clk),
    .en (en),
    .d  ({p4_r, contact_r}),
    .q  (side_s_q)
  );

  assign p_s = dpcr_pkg::pair_t'(side_s_q[PAIR_W:1]);
  assign c_s = side_s_q[0];

  // ---------------- unit normal ----------------
  logic signed [dpcr_pkg::DIFF_W-1:0] dxs, dys;
  logic signed [NUMN_W-1:0]           numx, numy;
  logic signed [NW-1:0]               nx_n, ny_n;
  logic [SIDE_N_W-1:0]                side_n_q;
  logic [PAIR_W-1:0]                  p_n_v;
  dpcr_pkg::pair_t                    p_n;
  logic                               c_n;
  logic [dpcr_pkg::DIST_W-1:0]        dist_n;

  assign dxs  = dpcr_pkg::DIFF_W'(p_s.pbx) - dpcr_pkg::DIFF_W'(p_s.pax);
  assign dys  = dpcr_pkg::DIFF_W'(p_s.pby) - dpcr_pkg::DIFF_W'(p_s.pay);
  assign numx = $signed({dxs[dpcr_pkg::DXN_W-1:0], {NB{1'b0}}});
  assign numy = $signed({dys[dpcr_pkg::DXN_W-1:0], {NB{1'b0}}});

  dpcr_rdiv #(.NUM_W(NUMN_W), .DEN_W(dpcr_pkg::DIST_W), .QW(NQ_W)) u_div_nx (
    .clk(clk), .en(en), .num(numx), .den(dist_s), .quo(nx_n)
  );

  dpcr_rdiv #(.NUM_W(NUMN_W), .DEN_W(dpcr_pkg::DIST_W), .QW(NQ_W)) u_div_ny (
    .clk(clk), .en(en), .num(numy), .den(dist_s), .quo(ny_n)
  );

  dpcr_delay #(.W(SIDE_N_W), .D(NDIV_LAT)) u_dly_norm (
    .clk(clk),
    .en (en),
    .d  ({p_s, c_s, dist_s}),
    .q  (side_n_q)
  );

  assign {p_n_v, c_n, dist_n} = side_n_q;
  assign p_n = dpcr_pkg::pair_t'(p_n_v);

  // ---------------- normal velocity ----------------
  dpcr_pkg::pair_t                    pa_r, pb_r, pc_r;
  logic                               ca_r, hit_b_r, hit_c_r;
  logic [dpcr_pkg::DIST_W-1:0]        dist_a_r, dist_b_r;
  logic signed [NW-1:0]               nx_a_r, ny_a_r, nx_b_r, ny_b_r, nx_c_r, ny_c_r;
  logic signed [PR_W-1:0]             prx_r, pry_r;
  logic signed [dpcr_pkg::DIFF_W-1:0] rx, ry;
  logic signed [SUM_W-1:0]            vsum;
  logic signed [dpcr_pkg::VN_W-1:0]   vn_nxt, vn_r;
  logic [dpcr_pkg::MASS_W-1:0]        mae, mbe;
  logic signed [dpcr_pkg::MPROD_W-1:0] mbvn_r, mavn_r;
  logic [dpcr_pkg::MSUM_W-1:0]        msum_r;
  logic signed [dpcr_pkg::GAP_W-1:0]  gap_r;

  assign rx     = dpcr_pkg::DIFF_W'(p_n.vbx) - dpcr_pkg::DIFF_W'(p_n.vax);
  assign ry     = dpcr_pkg::DIFF_W'(p_n.vby) - dpcr_pkg::DIFF_W'(p_n.vay);
  assign vsum   = (SUM_W'(prx_r) + SUM_W'(pry_r) + HALF_N) >>> NB;
  assign vn_nxt = vsum[dpcr_pkg::VN_W-1:0];

  // both masses zero counts as equal masses
  always_comb begin
    mae = pb_r.ma;
    mbe = pb_r.mb;
    if (pb_r.ma == '0 && pb_r.mb == '0) begin
      mae = dpcr_pkg::MASS_W'(1);
      mbe = dpcr_pkg::MASS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // projections onto the normal
      pa_r     <= p_n;
      ca_r     <= c_n;
      dist_a_r <= dist_n;
      nx_a_r   <= nx_n;
      ny_a_r   <= ny_n;
      prx_r    <= PR_W'(rx) * PR_W'(nx_n);
      pry_r    <= PR_W'(ry) * PR_W'(ny_n);
      // rounded normal speed, separating pairs drop out
      pb_r     <= pa_r;
      hit_b_r  <= ca_r && (vn_nxt <= 0);
      dist_b_r <= dist_a_r;
      nx_b_r   <= nx_a_r;
      ny_b_r   <= ny_a_r;
      vn_r     <= vn_nxt;
      // mass weighting products and overlap
      pc_r     <= pb_r;
      hit_c_r  <= hit_b_r;
      nx_c_r   <= nx_b_r;
      ny_c_r   <= ny_b_r;
      mbvn_r   <= dpcr_pkg::MPROD_W'($signed({1'b0, mbe})) * dpcr_pkg::MPROD_W'(vn_r);
      mavn_r   <= dpcr_pkg::MPROD_W'($signed({1'b0, mae})) * dpcr_pkg::MPROD_W'(vn_r);
      msum_r   <= dpcr_pkg::MSUM_W'(mae) + dpcr_pkg::MSUM_W'(mbe);
      gap_r    <= $signed({3'b000, pb_r.ra}) + $signed({3'b000, pb_r.rb})
                - $signed({1'b0, dist_b_r});
    end
  end

  // ---------------- velocity change per disc ----------------
  logic signed [dpcr_pkg::MNUM_W-1:0] numa, numb;
  logic signed [dpcr_pkg::DV_W-1:0]   dva, dvb;
  logic [SIDE_M_W-1:0]                side_m_q;
  logic [PAIR_W-1:0]                  p_m_v;
  logic                               h_m;
  logic signed [NW-1:0]               nx_m, ny_m;
  logic signed [dpcr_pkg::GAP_W-1:0]  gap_m;

  assign numa = $signed({mbvn_r, 1'b0});
  assign numb = $signed({mavn_r, 1'b0});

  dpcr_rdiv #(.NUM_W(dpcr_pkg::MNUM_W), .DEN_W(dpcr_pkg::MSUM_W), .QW(dpcr_pkg::MQ_W))
    u_div_dva (.clk(clk), .en(en), .num(numa), .den(msum_r), .quo(dva));

  dpcr_rdiv #(.NUM_W(dpcr_pkg::MNUM_W), .DEN_W(dpcr_pkg::MSUM_W), .QW(dpcr_pkg::MQ_W))
    u_div_dvb (.clk(clk), .en(en), .num(numb), .den(msum_r), .quo(dvb));

  dpcr_delay #(.W(SIDE_M_W), .D(MDIV_LAT)) u_dly_mass (
    .clk(clk),
    .en (en),
    .d  ({pc_r, hit_c_r, nx_c_r, ny_c_r, gap_r}),
    .q  (side_m_q)
  );

  assign {p_m_v, h_m, nx_m, ny_m, gap_m} = side_m_q;

  // ---------------- impulse and correction products ----------------
  dpcr_pkg::pair_t      pe_r;
  logic                 he_r;
  logic signed [MV_W-1:0] mvax_r, mvay_r, mvbx_r, mvby_r;
  logic signed [MC_W-1:0] mcx_r, mcy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pe_r   <= dpcr_pkg::pair_t'(p_m_v);
      he_r   <= h_m;
      mvax_r <= MV_W'(nx_m) * MV_W'(dva);
      mvay_r <= MV_W'(ny_m) * MV_W'(dva);
      mvbx_r <= MV_W'(nx_m) * MV_W'(dvb);
      mvby_r <= MV_W'(ny_m) * MV_W'(dvb);
      mcx_r  <= MC_W'(nx_m) * MC_W'(gap_m);
      mcy_r  <= MC_W'(ny_m) * MC_W'(gap_m);
    end
  end

  // ---------------- apply, saturate and register the result word ----------------
  logic signed [dpcr_pkg::ACC_W-1:0] tvax, tvay, tvbx, tvby, tcx, tcy;
  logic signed [dpcr_pkg::FIELD_W-1:0] pax_nxt, pay_nxt, pbx_nxt, pby_nxt;
  logic signed [dpcr_pkg::FIELD_W-1:0] vax_nxt, vay_nxt, vbx_nxt, vby_nxt;
  logic signed [dpcr_pkg::FIELD_W-1:0] pax_r, pay_r, pbx_r, pby_r;
  logic signed [dpcr_pkg::FIELD_W-1:0] vax_r, vay_r, vbx_r, vby_r;
  logic                                coll_r;

  always_comb begin
    tvax = dpcr_pkg::ACC_W'(((MV_W + 1)'(mvax_r) + HALF_V) >>> NB);
    tvay = dpcr_pkg::ACC_W'(((MV_W + 1)'(mvay_r) + HALF_V) >>> NB);
    tvbx = dpcr_pkg::ACC_W'(((MV_W + 1)'(mvbx_r) + HALF_V) >>> NB);
    tvby = dpcr_pkg::ACC_W'(((MV_W + 1)'(mvby_r) + HALF_V) >>> NB);
    tcx  = dpcr_pkg::ACC_W'(((MC_W + 1)'(mcx_r) + HALF_C) >>> (NB + 1));
    tcy  = dpcr_pkg::ACC_W'(((MC_W + 1)'(mcy_r) + HALF_C) >>> (NB + 1));
    if (he_r) begin
      pax_nxt = dpcr_pkg::sat_field(dpcr_pkg::ACC_W'(pe_r.pax) - tcx);
      pay_nxt = dpcr_pkg::sat_field(dpcr_pkg::ACC_W'(pe_r.pay) - tcy);
      pbx_nxt = dpcr_pkg::sat_field(dpcr_pkg::ACC_W'(pe_r.pbx) + tcx);
      pby_nxt = dpcr_pkg::sat_field(dpcr_pkg::ACC_W'(pe_r.pby) + tcy);
      vax_nxt = dpcr_pkg::sat_field(dpcr_pkg::ACC_W'(pe_r.vax) + tvax);
      vay_nxt = dpcr_pkg::sat_field(dpcr_pkg::ACC_W'(pe_r.vay) + tvay);
      vbx_nxt = dpcr_pkg::sat_field(dpcr_pkg::ACC_W'(pe_r.vbx) - tvbx);
      vby_nxt = dpcr_pkg::sat_field(dpcr_pkg::ACC_W'(pe_r.vby) - tvby);
    end else begin
      pax_nxt = pe_r.pax;
      pay_nxt = pe_r.pay;
      pbx_nxt = pe_r.pbx;
      pby_nxt = pe_r.pby;
      vax_nxt = pe_r.vax;
      vay_nxt = pe_r.vay;
      vbx_nxt = pe_r.vbx;
      vby_nxt = pe_r.vby;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pax_r  <= pax_nxt;
      pay_r  <= pay_nxt;
      pbx_r  <= pbx_nxt;
      pby_r  <= pby_nxt;
      vax_r  <= vax_nxt;
      vay_r  <= vay_nxt;
      vbx_r  <= vbx_nxt;
      vby_r  <= vby_nxt;
      coll_r <= he_r;
    end
  end

  assign out_valid       = vld_r[LAT-1];
  assign out_new_pos_a_x = pax_r;
  assign out_new_pos_a_y = pay_r;
  assign out_new_pos_b_x = pbx_r;
  assign out_new_pos_b_y = pby_r;
  assign out_new_vel_a_x = vax_r;
  assign out_new_vel_a_y = vay_r;
  assign out_new_vel_b_x = vbx_r;
  assign out_new_vel_b_y = vby_r;
  assign out_collided    = coll_r;

endmodule
